// ===== rtl/core/urd_pkg.sv =====
// Shared types and constants for the unsigned restoring divider.
// Used by the divider cell and the top level; depends on nothing else.
package urd_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int NUM_CELLS  = DATA_WIDTH;

  typedef logic [DATA_WIDTH-1:0] word_t;

  typedef struct packed {
    word_t dividend_value;
    word_t divisor_value;
  } urd_in_t;

  typedef struct packed {
    word_t quotient_value;
    word_t remainder_value;
    logic  zero_divisor_flag;
  } urd_out_t;

  // Work carried from cell to cell. The nq word starts as the dividend; each
  // step shifts out its top bit into the remainder and shifts in a quotient bit.
  typedef struct packed {
    logic  zdiv;
    word_t den;
    word_t rem;
    word_t nq;
  } stage_t;

endpackage

// ===== rtl/core/urd_cell.sv =====
// One restoring-division step with its own pipeline register and valid bit.
// Depends on urd_pkg for the stage type and the data width.
module urd_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            up_vld,
  input  urd_pkg::stage_t up_stage,
  output logic            up_en,
  input  logic            down_en,
  output logic            vld_r,
  output urd_pkg::stage_t stage_r
);
  import urd_pkg::*;

  logic                  carry;
  word_t                 shifted;
  logic [DATA_WIDTH:0]   diff;
  logic                  take;
  stage_t                stage_nxt;

  // The cell loads when it is empty or its content moves on in this cycle.
  assign up_en = !vld_r || down_en;

  // Trial subtraction at one extra bit keeps the carry out of the shift,
  // so divisors with the top bit set are handled correctly.
  always_comb begin
    carry   = up_stage.rem[DATA_WIDTH-1];
    shifted = {up_stage.rem[DATA_WIDTH-2:0], up_stage.nq[DATA_WIDTH-1]};
    diff    = {carry, shifted} - {1'b0, up_stage.den};
    take    = !diff[DATA_WIDTH];
    stage_nxt.zdiv = up_stage.zdiv;
    stage_nxt.den  = up_stage.den;
    stage_nxt.rem  = take ? diff[DATA_WIDTH-1:0] : shifted;
    stage_nxt.nq   = {up_stage.nq[DATA_WIDTH-2:0], take};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (up_en) begin
      vld_r <= up_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (up_en && up_vld) begin
      stage_r <= stage_nxt;
    end
  end

endmodule

// ===== rtl/core/unsigned_restoring_divider_top.sv =====
// Top level of the pipelined unsigned restoring divider: a chain of
// urd_cell instances, one per quotient bit. Depends on urd_pkg and urd_cell.
//
//   channel   direction  handshake             payload
//   in_       input      in_valid / in_stall    urd_pkg::urd_in_t
//   out_      output     out_valid / out_stall  urd_pkg::urd_out_t
//
// The chain holds one cell per quotient bit, and the last cell's register
// is the output register.
// Throughput is one transaction per cycle while the output is not stalled.
// Reset clears the valid bit of every cell; payload registers are not reset.
// A stalled output holds the last cell; empty cells upstream keep filling,
// and in_stall rises only when every cell holds a transaction.
module unsigned_restoring_divider_top (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  urd_pkg::urd_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output urd_pkg::urd_out_t out_data
);
  import urd_pkg::*;

  logic   vld   [NUM_CELLS+1];
  stage_t stage [NUM_CELLS+1];
  logic   en    [NUM_CELLS+1];
  logic [NUM_CELLS-1:0] vld_vec;

  // A zero divisor needs no special path: every trial subtraction succeeds,
  // giving an all-ones quotient and leaving the dividend as remainder.
  assign vld[0]        = in_valid;
  assign stage[0].zdiv = (in_data.divisor_value == '0);
  assign stage[0].den  = in_data.divisor_value;
  assign stage[0].rem  = '0;
  assign stage[0].nq   = in_data.dividend_value;

  assign en[NUM_CELLS] = !out_stall;

  for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
    urd_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_vld   (vld[k]),
      .up_stage (stage[k]),
      .up_en    (en[k]),
      .down_en  (en[k+1]),
      .vld_r    (vld[k+1]),
      .stage_r  (stage[k+1])
    );
    assign vld_vec[k] = vld[k+1];
  end

  assign in_stall                   = !en[0];
  assign out_valid                  = vld[NUM_CELLS];
  assign out_data.quotient_value    = stage[NUM_CELLS].nq;
  assign out_data.remainder_value   = stage[NUM_CELLS].rem;
  assign out_data.zero_divisor_flag = stage[NUM_CELLS].zdiv;

  // The input can only be held off when the whole chain is occupied.
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (&vld_vec))
    else $error("input stalled while the chain has an empty cell");

  a_zero_quot: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.zero_divisor_flag) |-> (out_data.quotient_value == '1))
    else $error("zero divisor did not give an all-ones quotient");

  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.zero_divisor_flag)
      |-> (out_data.remainder_value < stage[NUM_CELLS].den))
    else $error("remainder not below the divisor");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid)
    else $error("stalled result dropped from the last cell");

endmodule
